// File: src/sktrc_pkg.sv
// Package for the sorted key table with run compression.
// Holds entry, status and sequencer state types and mode constants; no dependencies.
package sktrc_pkg;

	localparam int unsigned KEY_W = 32;
	localparam int unsigned DLY_W = 8;
	localparam int unsigned ENTRY_W = KEY_W + 2 * DLY_W;
	localparam int unsigned CNT_W = 11;
	localparam int unsigned STATUS_W = 3;

	typedef struct packed {
		logic [DLY_W-1:0] fine;
		logic [DLY_W-1:0] coarse;
		logic [KEY_W-1:0] key;
	} entry_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL = 3'd2,
		ST_COMPRESSED = 3'd3,
		ST_HIT = 3'd4,
		ST_PAST_END = 3'd5
	} status_t;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_COMPRESS = 2'd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH,
		S_SRCH_WAIT,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PUT,
		S_CMP_RD,
		S_CMP_STEP,
		S_DONE
	} state_t;

endpackage

// File: src/sktrc_ram.sv
// Entry store: single-port-write, single-port-read synchronous memory.
// Read data is registered. Uses sktrc_pkg::entry_t.
module sktrc_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW = 10
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  sktrc_pkg::entry_t    wdata,
	input  logic [AW-1:0]        raddr,
	output sktrc_pkg::entry_t    rdata
);

	sktrc_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/sorted_key_table_with_run_compress.sv
// Sorted key table with run compression: an entry table sorted by a 32-bit key held in
// one synchronous RAM with registered read data, driven by a sequencer. One item is
// worked at a time. A lookup is a binary search. An insert searches, then moves each
// later entry up by one, reading it, then writing it one place higher. A compress
// walks the whole table once, one entry per cycle. The result beat sits in an output
// register; no new item is taken until it is taken. No clearing pass after reset is
// needed: entries at or above the valid count may be read but never decide a result.
// Depends on sktrc_pkg and sktrc_ram.
module sorted_key_table_with_run_compress #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,  // mode
	input  logic [47:0] s_tdata,  // key[31:0], coarse_value[39:32], fine_value[47:40]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [2:0]  m_tuser,  // status
	output logic [63:0] m_tdata   // entry_count[10:0], found_key[42:11],
	                              // found_coarse[50:43], found_fine[58:51], zero pad
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	sktrc_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q;          // valid entries
	logic [CW-1:0] lo_q, hi_q;       // search bounds, then shift / compress cursors
	logic [CW-1:0] wr_q;             // compress write pointer
	logic [1:0]    mode_q;
	sktrc_pkg::entry_t in_q;         // captured input entry
	sktrc_pkg::entry_t prev_q;       // compress: entry just before the read cursor
	logic [2:0]    status_q;
	sktrc_pkg::entry_t found_q;

	// RAM
	logic              we;
	logic [AW-1:0]     waddr, raddr;
	sktrc_pkg::entry_t wdata, rdata;

	sktrc_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [CW-1:0] mid;
	logic [CW:0]   mid_sum;
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = mid_sum[CW:1];

	assign s_tready = (state_q == sktrc_pkg::S_IDLE);
	assign m_tvalid = (state_q == sktrc_pkg::S_DONE);
	assign m_tuser = status_q;
	assign m_tdata = {5'd0, found_q.fine, found_q.coarse, found_q.key,
		sktrc_pkg::CNT_W'(count_q)};

	logic pos_hit;   // lower bound lies inside the table
	assign pos_hit = (lo_q < count_q);

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = AW'(lo_q);
		wdata = in_q;
		raddr = AW'(mid);
		case (state_q)
			sktrc_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = (s_tuser[1] || s_tuser == sktrc_pkg::MODE_INSERT) ?
						sktrc_pkg::S_SRCH : sktrc_pkg::S_CMP_RD;
				end
			end
			sktrc_pkg::S_SRCH: begin
				// issue read at mid, or finish
				state_d = (lo_q < hi_q) ? sktrc_pkg::S_SRCH_WAIT : sktrc_pkg::S_DECIDE;
				raddr = AW'(mid);
			end
			sktrc_pkg::S_SRCH_WAIT: state_d = sktrc_pkg::S_SRCH;
			sktrc_pkg::S_DECIDE: begin
				// read entry at lower bound
				raddr = AW'(lo_q);
				state_d = sktrc_pkg::S_SHIFT_RD;
			end
			sktrc_pkg::S_SHIFT_RD: begin
				// first visit: rdata holds entry at pos; decide outcome
				if (mode_q[1]) begin
					state_d = sktrc_pkg::S_DONE;
				end else if (pos_hit && rdata.key == in_q.key) begin
					state_d = sktrc_pkg::S_DONE;
				end else if (count_q >= CW'(TABLE_DEPTH)) begin
					state_d = sktrc_pkg::S_DONE;
				end else if (hi_q == lo_q) begin
					state_d = sktrc_pkg::S_PUT;
				end else begin
					raddr = AW'(hi_q - 1'b1);
					state_d = sktrc_pkg::S_SHIFT_WR;
				end
			end
			sktrc_pkg::S_SHIFT_WR: begin
				// rdata = entry hi-1, move it to hi
				we = 1'b1;
				waddr = AW'(hi_q);
				wdata = rdata;
				raddr = AW'(hi_q - 2'd2);
				state_d = (hi_q - 1'b1 == lo_q) ? sktrc_pkg::S_PUT : sktrc_pkg::S_SHIFT_WR;
				if (hi_q - 1'b1 != lo_q) state_d = sktrc_pkg::S_CMP_STEP;
			end
			sktrc_pkg::S_PUT: begin
				we = 1'b1;
				waddr = AW'(lo_q);
				wdata = in_q;
				state_d = sktrc_pkg::S_DONE;
			end
			sktrc_pkg::S_CMP_RD: begin
				// compress: prime read of entry 0
				raddr = '0;
				state_d = (count_q == '0) ? sktrc_pkg::S_DONE : sktrc_pkg::S_CMP_STEP;
			end
			sktrc_pkg::S_CMP_STEP: begin
				if (mode_q != sktrc_pkg::MODE_COMPRESS) begin
					// insert shift: wait cycle so the read of hi-1 lands
					raddr = AW'(hi_q - 1'b1);
					state_d = sktrc_pkg::S_SHIFT_WR;
				end else begin
					// rdata = entry lo (read cursor lo-1 held in prev_q)
					raddr = AW'(lo_q + 1'b1);
					if (lo_q != '0 && (rdata.coarse != prev_q.coarse ||
						rdata.fine != prev_q.fine)) begin
						we = 1'b1;
						waddr = AW'(wr_q);
						wdata = prev_q;
					end
					if (lo_q == count_q) begin
						state_d = sktrc_pkg::S_DONE;
						we = 1'b1;
						waddr = AW'(wr_q);
						wdata = prev_q;
					end
				end
			end
			sktrc_pkg::S_DONE: begin
				if (m_tready) state_d = sktrc_pkg::S_IDLE;
			end
			default: state_d = sktrc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sktrc_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sktrc_pkg::S_PUT) count_q <= count_q + 1'b1;
			if (state_q == sktrc_pkg::S_CMP_STEP && mode_q == sktrc_pkg::MODE_COMPRESS &&
				lo_q == count_q) begin
				count_q <= wr_q + 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			sktrc_pkg::S_IDLE: begin
				mode_q <= s_tuser;
				in_q.key <= s_tdata[31:0];
				in_q.coarse <= s_tdata[39:32];
				in_q.fine <= s_tdata[47:40];
				lo_q <= '0;
				hi_q <= count_q;
				wr_q <= '0;
				found_q <= '0;
				status_q <= sktrc_pkg::ST_COMPRESSED;
			end
			sktrc_pkg::S_SRCH_WAIT: begin
				if (rdata.key < in_q.key) lo_q <= mid + 1'b1;
				else hi_q <= mid;
			end
			sktrc_pkg::S_DECIDE: hi_q <= count_q;
			sktrc_pkg::S_SHIFT_RD: begin
				if (mode_q[1]) begin
					status_q <= pos_hit ? sktrc_pkg::ST_HIT : sktrc_pkg::ST_PAST_END;
					if (pos_hit) found_q <= rdata;
				end else if (pos_hit && rdata.key == in_q.key) begin
					status_q <= sktrc_pkg::ST_DUPLICATE;
				end else if (count_q >= CW'(TABLE_DEPTH)) begin
					status_q <= sktrc_pkg::ST_FULL;
				end else begin
					status_q <= sktrc_pkg::ST_INSERTED;
				end
			end
			sktrc_pkg::S_SHIFT_WR: hi_q <= hi_q - 1'b1;
			sktrc_pkg::S_CMP_STEP: begin
				if (mode_q == sktrc_pkg::MODE_COMPRESS) begin
					prev_q <= rdata;
					lo_q <= lo_q + 1'b1;
					if (lo_q != '0 && (rdata.coarse != prev_q.coarse ||
						rdata.fine != prev_q.fine)) begin
						wr_q <= wr_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

endmodule
